>>> rtl/phtt_pkg.sv
// phtt_pkg: shared types and constants of the PC-sampling histogram block.
// Depends on nothing; phtt_cell, the top and phtt_checker import it.
`timescale 1ns / 1ps
package phtt_pkg;

  localparam int          CFG_W         = 13;
  localparam logic [31:0] TEXT_BASE     = 32'h0000_8000;
  localparam logic [31:0] PC_OFFSET     = 32'd4;
  localparam logic [CFG_W-1:0] TEXT_WORDS_RST = 13'd4096;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAMP_RD,
    ST_SAMP_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rec_addr;
    logic [31:0] rec_count;
    logic        is_last;
    logic        empty_res;
    logic        dropped_flag;
  } out_item_t;

endpackage

>>> rtl/phtt_chan_if.sv
// phtt_chan_if: valid/ready channel carrying one payload of type T.
// Depends on nothing; the payload types come from phtt_pkg at instantiation.
`timescale 1ns / 1ps
interface phtt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/phtt_ram.sv
// phtt_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module phtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/phtt_cell.sv
// phtt_cell: one stage of the systolic top-N sorter. Keeps the best entry seen
// so far and hands the loser on to the next cell through a register. Uses phtt_pkg.
`timescale 1ns / 1ps
module phtt_cell #(
  parameter int IW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          in_vld,
  input  logic [IW-1:0] in_idx,
  input  logic [31:0]   in_cnt,
  output logic          held_vld,
  output logic [IW-1:0] held_idx,
  output logic [31:0]   held_cnt,
  output logic          pass_vld,
  output logic [IW-1:0] pass_idx,
  output logic [31:0]   pass_cnt
);
  import phtt_pkg::*;

  logic take;

  // higher count wins; on equal counts the lower word index wins
  assign take = in_vld && (!held_vld || (in_cnt > held_cnt) ||
                ((in_cnt == held_cnt) && (in_idx < held_idx)));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      held_vld <= 1'b0;
      pass_vld <= 1'b0;
    end else begin
      if (take) begin
        held_vld <= 1'b1;
        pass_vld <= held_vld;
      end else begin
        pass_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_idx <= in_idx;
      held_cnt <= in_cnt;
      pass_idx <= held_idx;
      pass_cnt <= held_cnt;
    end else begin
      pass_idx <= in_idx;
      pass_cnt <= in_cnt;
    end
  end

endmodule

>>> rtl/pc_sample_histogram_top_ten_top.sv
// Channel  | Dir | Payload                                  | Accepted when
// cfg      | in  | text_words (13 bits)                     | cfg.valid & cfg.ready
// item     | in  | action (2), pc (32)                      | item.valid & item.ready
// result   | out | rec_addr, rec_count, is_last, empty_res, | result.valid & result.ready
//          |     | dropped_flag                             |
//
// Stop and ignored transactions are taken in ST_IDLE alone; a sample also passes
// ST_SAMP_RD and ST_SAMP_WR (read, write back through the single counter RAM
// port pair). A start while inactive runs a clearing pass over all NUM_WORDS
// words of the counter RAM; the same pass follows reset. A dump scans
// min(text_words, NUM_WORDS) counters at one per cycle, then drains the TOP_N-cell
// sorter chain, then hands out one result per cycle while result.ready stays
// high. No new transaction is taken until all results of a dump are gone.
// Depends on phtt_pkg, phtt_chan_if, phtt_ram and phtt_cell.
`timescale 1ns / 1ps
module pc_sample_histogram_top_ten_top #(
  parameter int NUM_WORDS = 4096,
  parameter int TOP_N     = 10
) (
  input logic         clk,
  input logic         rst,
  phtt_chan_if.sink   cfg,
  phtt_chan_if.sink   item,
  phtt_chan_if.source result
);
  import phtt_pkg::*;

  localparam int IW   = $clog2(NUM_WORDS);
  localparam int LIMW = $clog2(NUM_WORDS + 1);
  localparam int KW   = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  state_t          state, state_next;
  logic            active;
  logic            dropped;
  cfg_word_t       text_words;
  logic [IW-1:0]   clr_cnt;
  logic [LIMW-1:0] scan_cnt;
  logic [IW-1:0]   samp_idx;
  logic            rd_vld;
  logic [IW-1:0]   rd_idx;
  logic [KW-1:0]   out_k;

  logic [LIMW-1:0] lim;
  logic [31:0]     pc_off;
  logic            samp_in_range;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  logic            cell_clr;
  logic            held_vld [TOP_N];
  logic [IW-1:0]   held_idx [TOP_N];
  logic [31:0]     held_cnt [TOP_N];
  logic [TOP_N-1:0] pass_vld;
  logic [IW-1:0]   pass_idx [TOP_N];
  logic [31:0]     pass_cnt [TOP_N];
  logic [TOP_N-1:0] succ_vld;
  logic            res_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_words <= TEXT_WORDS_RST;
    end else if (cfg.valid) begin
      text_words <= cfg.data;
    end
  end

  always_comb begin
    if (32'(text_words) < 32'(NUM_WORDS)) begin
      lim = LIMW'(text_words);
    end else begin
      lim = LIMW'(NUM_WORDS);
    end
  end

  // pc-4 wraps modulo 2^32, so anything below the base lands far above the limit
  assign pc_off        = item.data.pc - PC_OFFSET - TEXT_BASE;
  assign samp_in_range = {2'b00, pc_off[31:2]} < 32'(lim);

  phtt_ram #(
    .WIDTH (32),
    .DEPTH (NUM_WORDS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar j = 0; j < TOP_N; j++) begin : g_cell
    logic          c_in_vld;
    logic [IW-1:0] c_in_idx;
    logic [31:0]   c_in_cnt;

    if (j == 0) begin : g_head
      // zero counters never enter the sorter
      assign c_in_vld = rd_vld && (ram_rdata != 32'd0);
      assign c_in_idx = rd_idx;
      assign c_in_cnt = ram_rdata;
    end else begin : g_link
      assign c_in_vld = pass_vld[j-1];
      assign c_in_idx = pass_idx[j-1];
      assign c_in_cnt = pass_cnt[j-1];
    end

    if (j == TOP_N - 1) begin : g_tail
      assign succ_vld[j] = 1'b0;
    end else begin : g_mid
      assign succ_vld[j] = held_vld[j+1];
    end

    phtt_cell #(
      .IW (IW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (cell_clr),
      .in_vld   (c_in_vld),
      .in_idx   (c_in_idx),
      .in_cnt   (c_in_cnt),
      .held_vld (held_vld[j]),
      .held_idx (held_idx[j]),
      .held_cnt (held_cnt[j]),
      .pass_vld (pass_vld[j]),
      .pass_idx (pass_idx[j]),
      .pass_cnt (pass_cnt[j])
    );
  end

  assign res_last = !held_vld[0] || !succ_vld[out_k];

  always_comb begin
    result.data.rec_addr     = '0;
    result.data.rec_count    = '0;
    result.data.is_last      = res_last;
    result.data.empty_res    = !held_vld[0];
    result.data.dropped_flag = dropped;
    if (held_vld[0]) begin
      result.data.rec_addr  = TEXT_BASE + 32'({held_idx[out_k], 2'b00});
      result.data.rec_count = held_cnt[out_k];
    end
  end

  always_comb begin
    state_next   = state;
    item.ready   = 1'b0;
    result.valid = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = clr_cnt;
    ram_wdata    = '0;
    ram_raddr    = scan_cnt[IW-1:0];
    cell_clr     = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == IW'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.data.action)
            ACT_START: begin
              if (!active) begin
                state_next = ST_CLEAR;
              end
            end
            ACT_SAMPLE: begin
              if (active && samp_in_range) begin
                state_next = ST_SAMP_RD;
              end
            end
            ACT_DUMP: begin
              cell_clr   = 1'b1;
              state_next = (lim == '0) ? ST_DRAIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SAMP_RD: begin
        ram_raddr  = samp_idx;
        state_next = ST_SAMP_WR;
      end
      ST_SAMP_WR: begin
        // saturate at all ones
        ram_we     = 1'b1;
        ram_waddr  = samp_idx;
        ram_wdata  = (&ram_rdata) ? ram_rdata : ram_rdata + 32'd1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_cnt == lim - LIMW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // done once nothing is left in flight along the chain
        if (!rd_vld && !(|pass_vld)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        result.valid = 1'b1;
        if (result.ready && res_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      active   <= 1'b0;
      dropped  <= 1'b0;
      clr_cnt  <= '0;
      scan_cnt <= '0;
      rd_vld   <= 1'b0;
      out_k    <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + LIMW'(1);
      end
      if (state == ST_OUT && result.ready) begin
        out_k <= out_k + KW'(1);
      end
      if (state == ST_IDLE && item.valid) begin
        case (item.data.action)
          ACT_START: begin
            if (!active) begin
              active  <= 1'b1;
              dropped <= 1'b0;
              clr_cnt <= '0;
            end
          end
          ACT_STOP: begin
            active <= 1'b0;
          end
          ACT_SAMPLE: begin
            if (active && !samp_in_range) begin
              dropped <= 1'b1;
            end
          end
          ACT_DUMP: begin
            scan_cnt <= '0;
            out_k    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      samp_idx <= pc_off[IW+1:2];
    end
    rd_idx <= scan_cnt[IW-1:0];
  end

endmodule

>>> rtl/phtt_checker.sv
// phtt_props: port-level assertions on the histogram block, bound to its top.
// Depends on phtt_pkg.
`timescale 1ns / 1ps
module phtt_props (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               res_valid,
  input logic               res_ready,
  input phtt_pkg::out_item_t res_data
);
  import phtt_pkg::*;

  // no new transaction while dump results are still pending
  a_no_accept_during_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !item_ready)
    else $error("item ready while results pending");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.empty_res |-> res_data.is_last)
    else $error("empty result not marked last");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.empty_res |-> res_data.rec_count != 32'd0)
    else $error("non-empty result with zero count");

  // the clearing pass follows reset, so nothing is taken straight away
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item_ready)
    else $error("item ready before clearing pass");

endmodule

bind pc_sample_histogram_top_ten_top phtt_props u_phtt_props (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.data)
);
